### rtl/aesgcm_pkg.sv
// Shared types, constants and lookup tables for the AES-256-GCM stream engine.
`default_nettype none

package aesgcm_pkg;

   localparam int unsigned ROUNDS_DEFAULT = 14;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_AAD    = 2'd1,
      OP_TEXT   = 2'd2,
      OP_FINISH = 2'd3
   } opcode_type;

   localparam logic [1:0] KIND_TEXT    = 2'd0;
   localparam logic [1:0] KIND_TAG     = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   localparam logic [2:0] REG_KEY0   = 3'd0;
   localparam logic [2:0] REG_KEY1   = 3'd1;
   localparam logic [2:0] REG_KEY2   = 3'd2;
   localparam logic [2:0] REG_KEY3   = 3'd3;
   localparam logic [2:0] REG_NONCEH = 3'd4;
   localparam logic [2:0] REG_NONCEL = 3'd5;
   localparam logic [2:0] REG_MODE   = 3'd6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] chunk_data;
      logic [3:0]  chunk_bytes;
      logic [63:0] expected_tag_high;
      logic [63:0] expected_tag_low;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] data_out;
      logic [3:0]  byte_count;
      logic        auth_ok;
      logic        last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      AES_ZERO = 2'd0,
      AES_CTR  = 2'd1,
      AES_J0   = 2'd2
   } aes_src_type;

   typedef enum logic [1:0] {
      OUT_TEXT    = 2'd0,
      OUT_HI      = 2'd1,
      OUT_LO      = 2'd2,
      OUT_VERDICT = 2'd3
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        key_load;
      logic        aes_start;
      aes_src_type aes_sel;
      logic        set_hkey;
      logic        gh_start;
      logic        gh_len;
      logic        set_text;
      logic        byte_step;
      logic        count_add;
      logic        load_ks;
      logic        tag_load;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       n_zero;
      logic       text_started;
      logic       fill_nz;
      logic       fill_full;
      logic       bytes_done;
      logic       ks_empty;
      logic       kx_done;
      logic       aes_done;
      logic       gh_done;
      logic       decrypt;
      logic       out_free;
   } sts_type;

   localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

`default_nettype wire

### rtl/aesgcm_cipher.sv
// AES-256 key schedule and one-round-per-cycle block cipher unit.
`default_nettype none

module aesgcm_cipher #(
   parameter int unsigned ROUND_COUNT = aesgcm_pkg::ROUNDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [255:0] key,
   input  logic         key_load,
   output logic         kx_done,
   input  logic         enc_start,
   input  logic [127:0] enc_block,
   output logic         enc_done,
   output logic [127:0] enc_result
);
   import aesgcm_pkg::*;

   localparam int unsigned RW = $clog2(ROUND_COUNT + 1);

   logic [127:0]  rk_ff [ROUND_COUNT + 1];
   logic [255:0]  win_ff, win_in;
   logic [RW-1:0] kx_idx_ff, kx_idx_in;
   logic          kx_busy_ff, kx_busy_in;
   logic          kx_done_ff, kx_done_in;
   logic [127:0]  st_ff, st_in;
   logic [RW-1:0] rnd_ff, rnd_in;
   logic          enc_busy_ff, enc_busy_in;
   logic          enc_done_ff, enc_done_in;
   logic [31:0]   kx_t;
   logic [RW-1:0] rc_idx;
   logic [7:0]    rc;
   logic [127:0]  kx_new;
   logic [31:0]   w0, w1, w2, w3;

   function automatic logic [7:0] xt(input logic [7:0] b);
      xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                              input logic last_round);
      logic [7:0] a [16];
      logic [7:0] t [16];
      logic [7:0] e;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         a[i] = SBOX[s[127 - 8*i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4*c] = a[i + 4*((c + i) & 3)];
         end
      end
      if (!last_round) begin
         for (int c = 0; c < 4; c++) begin
            e = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            a[4*c]   = t[4*c]   ^ e ^ xt(t[4*c]   ^ t[4*c+1]);
            a[4*c+1] = t[4*c+1] ^ e ^ xt(t[4*c+1] ^ t[4*c+2]);
            a[4*c+2] = t[4*c+2] ^ e ^ xt(t[4*c+2] ^ t[4*c+3]);
            a[4*c+3] = t[4*c+3] ^ e ^ xt(t[4*c+3] ^ t[4*c]);
         end
         for (int i = 0; i < 16; i++) begin
            t[i] = a[i];
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = t[i];
      end
      aes_round = r ^ k;
   endfunction

   // Next four schedule words from the sliding window of the last eight.
   always_comb begin
      rc_idx = (kx_idx_ff >> 1) - RW'(1);
      rc     = (rc_idx < RW'(7)) ? RCON[rc_idx[2:0]] : 8'h00;
      if (!kx_idx_ff[0]) begin
         kx_t = sub_word({win_ff[23:0], win_ff[31:24]}) ^ {rc, 24'h0};
      end else begin
         kx_t = sub_word(win_ff[31:0]);
      end
      w0     = win_ff[255:224] ^ kx_t;
      w1     = win_ff[223:192] ^ w0;
      w2     = win_ff[191:160] ^ w1;
      w3     = win_ff[159:128] ^ w2;
      kx_new = {w0, w1, w2, w3};
   end

   always_comb begin
      win_in      = win_ff;
      kx_idx_in   = kx_idx_ff;
      kx_busy_in  = kx_busy_ff;
      kx_done_in  = 1'b0;
      st_in       = st_ff;
      rnd_in      = rnd_ff;
      enc_busy_in = enc_busy_ff;
      enc_done_in = 1'b0;
      if (key_load) begin
         win_in     = key;
         kx_idx_in  = RW'(2);
         kx_busy_in = 1'b1;
      end else if (kx_busy_ff) begin
         win_in    = {win_ff[127:0], kx_new};
         kx_idx_in = kx_idx_ff + RW'(1);
         if (kx_idx_ff == RW'(ROUND_COUNT)) begin
            kx_busy_in = 1'b0;
            kx_done_in = 1'b1;
         end
      end
      if (enc_start) begin
         st_in       = enc_block ^ rk_ff[0];
         rnd_in      = RW'(1);
         enc_busy_in = 1'b1;
      end else if (enc_busy_ff) begin
         st_in  = aes_round(st_ff, rk_ff[rnd_ff], rnd_ff == RW'(ROUND_COUNT));
         rnd_in = rnd_ff + RW'(1);
         if (rnd_ff == RW'(ROUND_COUNT)) begin
            enc_busy_in = 1'b0;
            enc_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_load) begin
         rk_ff[0] <= key[255:128];
         rk_ff[1] <= key[127:0];
      end else if (kx_busy_ff) begin
         rk_ff[kx_idx_ff] <= kx_new;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      kx_idx_ff <= kx_idx_in;
      st_ff     <= st_in;
      rnd_ff    <= rnd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kx_busy_ff  <= 1'b0;
         kx_done_ff  <= 1'b0;
         enc_busy_ff <= 1'b0;
         enc_done_ff <= 1'b0;
      end else begin
         kx_busy_ff  <= kx_busy_in;
         kx_done_ff  <= kx_done_in;
         enc_busy_ff <= enc_busy_in;
         enc_done_ff <= enc_done_in;
      end
   end

   assign kx_done    = kx_done_ff;
   assign enc_done   = enc_done_ff;
   assign enc_result = st_ff;

endmodule

`default_nettype wire

### rtl/aesgcm_ghash.sv
// GF(2^128) multiplier for GHASH, eight multiplier bits per cycle.
`default_nettype none

module aesgcm_ghash (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] x,
   input  logic [127:0] h,
   output logic         done,
   output logic [127:0] product
);
   import aesgcm_pkg::*;

   logic [127:0] x_ff, x_in;
   logic [127:0] v_ff, v_in;
   logic [127:0] z_ff, z_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [127:0] zs, vs;
   logic         lsb;

   always_comb begin
      zs = z_ff;
      vs = v_ff;
      for (int j = 0; j < 8; j++) begin
         if (x_ff[127 - j]) begin
            zs = zs ^ vs;
         end
         lsb = vs[0];
         vs  = vs >> 1;
         if (lsb) begin
            vs[127:120] = vs[127:120] ^ 8'he1;
         end
      end
   end

   always_comb begin
      x_in    = x_ff;
      v_in    = v_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = x;
         v_in    = h;
         z_in    = '0;
         cnt_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = {x_ff[119:0], 8'h00};
         v_in   = vs;
         z_in   = zs;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      v_ff   <= v_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = z_ff;

endmodule

`default_nettype wire

### rtl/aesgcm_dp.sv
// Datapath: message state, byte lane, hash buffer, counters and output register.
`default_nettype none

module aesgcm_dp #(
   parameter int unsigned ROUND_COUNT = aesgcm_pkg::ROUNDS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  aesgcm_pkg::cmd_type        cmd,
   output aesgcm_pkg::sts_type        sts,
   input  aesgcm_pkg::req_word_type   req_data,
   input  logic [255:0]               key,
   input  logic [63:0]                nonce_high,
   input  logic [31:0]                nonce_low,
   input  logic                       decrypt,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output aesgcm_pkg::rsp_word_type   rsp_data
);
   import aesgcm_pkg::*;

   opcode_type   op_ff, op_in;
   logic [63:0]  chunk_ff, chunk_in;
   logic [3:0]   n_ff, n_in;
   logic [3:0]   k_ff, k_in;
   logic [63:0]  exp_hi_ff, exp_hi_in;
   logic [63:0]  exp_lo_ff, exp_lo_in;
   logic [63:0]  res_ff, res_in;
   logic [127:0] hkey_ff, hkey_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  ctr_ff, ctr_in;
   logic [127:0] ks_ff, ks_in;
   logic [4:0]   rem_ff, rem_in;
   logic [127:0] hb_ff, hb_in;
   logic [4:0]   fill_ff, fill_in;
   logic [60:0]  aad_cnt_ff, aad_cnt_in;
   logic [60:0]  txt_cnt_ff, txt_cnt_in;
   logic         started_ff, started_in;
   logic [127:0] tag_ff, tag_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   logic         kx_done, enc_done, gh_done;
   logic [127:0] enc_block, enc_result, gh_x, gh_product;
   logic [31:0]  ctr_next;
   logic [7:0]   b_in, ob, hbyte;
   logic         is_text, out_free;

   assign ctr_next = ctr_ff + 32'd1;
   assign is_text  = (op_ff == OP_TEXT);
   assign b_in     = chunk_ff[63:56];
   assign ob       = b_in ^ ks_ff[127:120];
   assign hbyte    = (is_text && !decrypt) ? ob : b_in;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.aes_sel)
         AES_CTR: enc_block = {nonce_high, nonce_low, ctr_next};
         AES_J0:  enc_block = {nonce_high, nonce_low, 32'd1};
         default: enc_block = '0;
      endcase
   end

   assign gh_x = acc_ff ^ (cmd.gh_len ? {aad_cnt_ff, 3'b000, txt_cnt_ff, 3'b000} : hb_ff);

   aesgcm_cipher #(
      .ROUND_COUNT(ROUND_COUNT)
   ) u_cipher (
      .clock     (clock),
      .reset     (reset),
      .key       (key),
      .key_load  (cmd.key_load),
      .kx_done   (kx_done),
      .enc_start (cmd.aes_start),
      .enc_block (enc_block),
      .enc_done  (enc_done),
      .enc_result(enc_result)
   );

   aesgcm_ghash u_ghash (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.gh_start),
      .x      (gh_x),
      .h      (hkey_ff),
      .done   (gh_done),
      .product(gh_product)
   );

   always_comb begin
      op_in        = op_ff;
      chunk_in     = chunk_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      exp_hi_in    = exp_hi_ff;
      exp_lo_in    = exp_lo_ff;
      res_in       = res_ff;
      hkey_in      = hkey_ff;
      acc_in       = acc_ff;
      ctr_in       = ctr_ff;
      ks_in        = ks_ff;
      rem_in       = rem_ff;
      hb_in        = hb_ff;
      fill_in      = fill_ff;
      aad_cnt_in   = aad_cnt_ff;
      txt_cnt_in   = txt_cnt_ff;
      started_in   = started_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (cmd.capture) begin
         op_in     = opcode_type'(req_data.opcode);
         chunk_in  = req_data.chunk_data;
         n_in      = (req_data.chunk_bytes > 4'd8) ? 4'd8 : req_data.chunk_bytes;
         k_in      = 4'd0;
         res_in    = '0;
         exp_hi_in = req_data.expected_tag_high;
         exp_lo_in = req_data.expected_tag_low;
      end
      if (cmd.set_hkey) begin
         hkey_in    = enc_result;
         acc_in     = '0;
         ks_in      = '0;
         rem_in     = 5'd0;
         hb_in      = '0;
         fill_in    = 5'd0;
         aad_cnt_in = '0;
         txt_cnt_in = '0;
         started_in = 1'b0;
         ctr_in     = 32'd1;
      end
      if (cmd.aes_start && cmd.aes_sel == AES_CTR) begin
         ctr_in = ctr_next;
      end
      if (cmd.load_ks) begin
         ks_in  = enc_result;
         rem_in = 5'd16;
      end
      if (cmd.gh_start && !cmd.gh_len) begin
         hb_in   = '0;
         fill_in = 5'd0;
      end
      if (gh_done) begin
         acc_in = gh_product;
      end
      if (cmd.set_text) begin
         started_in = 1'b1;
      end
      if (cmd.byte_step) begin
         hb_in    = hb_ff | ({hbyte, 120'h0} >> {fill_ff[3:0], 3'b000});
         fill_in  = fill_ff + 5'd1;
         chunk_in = {chunk_ff[55:0], 8'h00};
         k_in     = k_ff + 4'd1;
         if (is_text) begin
            res_in = res_ff | ({ob, 56'h0} >> {k_ff[2:0], 3'b000});
            ks_in  = {ks_ff[119:0], 8'h00};
            rem_in = rem_ff - 5'd1;
         end
      end
      if (cmd.count_add) begin
         if (is_text) begin
            txt_cnt_in = txt_cnt_ff + {57'd0, n_ff};
         end else begin
            aad_cnt_in = aad_cnt_ff + {57'd0, n_ff};
         end
      end
      if (cmd.tag_load) begin
         tag_in = acc_ff ^ enc_result;
      end
      if (cmd.out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.auth_ok     = 1'b0;
         rsp_in.last        = 1'b1;
         rsp_in.byte_count  = 4'd8;
         case (cmd.out_sel)
            OUT_TEXT: begin
               rsp_in.result_kind = KIND_TEXT;
               rsp_in.data_out    = res_ff;
               rsp_in.byte_count  = n_ff;
            end
            OUT_HI: begin
               rsp_in.result_kind = KIND_TAG;
               rsp_in.data_out    = tag_ff[127:64];
               rsp_in.last        = 1'b0;
            end
            OUT_LO: begin
               rsp_in.result_kind = KIND_TAG;
               rsp_in.data_out    = tag_ff[63:0];
            end
            default: begin
               rsp_in.result_kind = KIND_VERDICT;
               rsp_in.data_out    = '0;
               rsp_in.byte_count  = 4'd0;
               rsp_in.auth_ok     = (tag_ff == {exp_hi_ff, exp_lo_ff});
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_in_reg : begin
         op_ff     <= op_in;
         chunk_ff  <= chunk_in;
         n_ff      <= n_in;
         k_ff      <= k_in;
         exp_hi_ff <= exp_hi_in;
         exp_lo_ff <= exp_lo_in;
         res_ff    <= res_in;
         tag_ff    <= tag_in;
         rsp_ff    <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hkey_ff      <= '0;
         acc_ff       <= '0;
         ctr_ff       <= '0;
         ks_ff        <= '0;
         rem_ff       <= '0;
         hb_ff        <= '0;
         fill_ff      <= '0;
         aad_cnt_ff   <= '0;
         txt_cnt_ff   <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hkey_ff      <= hkey_in;
         acc_ff       <= acc_in;
         ctr_ff       <= ctr_in;
         ks_ff        <= ks_in;
         rem_ff       <= rem_in;
         hb_ff        <= hb_in;
         fill_ff      <= fill_in;
         aad_cnt_ff   <= aad_cnt_in;
         txt_cnt_ff   <= txt_cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sts.op           = op_ff;
      sts.n_zero       = (n_ff == 4'd0);
      sts.text_started = started_ff;
      sts.fill_nz      = (fill_ff != 5'd0);
      sts.fill_full    = (fill_ff == 5'd16);
      sts.bytes_done   = (k_ff == n_ff);
      sts.ks_empty     = (rem_ff == 5'd0);
      sts.kx_done      = kx_done;
      sts.aes_done     = enc_done;
      sts.gh_done      = gh_done;
      sts.decrypt      = decrypt;
      sts.out_free     = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/aesgcm_ctrl.sv
// Controller: sequences key set-up, byte processing, hashing and result delivery.
`default_nettype none

module aesgcm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  aesgcm_pkg::sts_type sts,
   output aesgcm_pkg::cmd_type cmd
);
   import aesgcm_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_DISPATCH  = 14'b00000000000010,
      S_KEYX      = 14'b00000000000100,
      S_HAES      = 14'b00000000001000,
      S_BYTE      = 14'b00000000010000,
      S_CAES      = 14'b00000000100000,
      S_BGH       = 14'b00000001000000,
      S_EMIT_TEXT = 14'b00000010000000,
      S_FPADW     = 14'b00000100000000,
      S_FLEN      = 14'b00001000000000,
      S_FLENW     = 14'b00010000000000,
      S_FAESW     = 14'b00100000000000,
      S_EMIT_HI   = 14'b01000000000000,
      S_EMIT_LO   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.op)
               OP_START: begin
                  cmd.key_load = 1'b1;
                  state_in     = S_KEYX;
               end
               OP_AAD: begin
                  state_in = (sts.text_started || sts.n_zero) ? S_IDLE : S_BYTE;
               end
               OP_TEXT: begin
                  if (sts.n_zero) begin
                     state_in = S_IDLE;
                  end else if (!sts.text_started) begin
                     cmd.set_text = 1'b1;
                     if (sts.fill_nz) begin
                        cmd.gh_start = 1'b1;
                        state_in     = S_BGH;
                     end else begin
                        state_in = S_BYTE;
                     end
                  end else begin
                     state_in = S_BYTE;
                  end
               end
               default: begin
                  if (sts.fill_nz) begin
                     cmd.gh_start = 1'b1;
                     state_in     = S_FPADW;
                  end else begin
                     state_in = S_FLEN;
                  end
               end
            endcase
         end
         S_KEYX: begin
            if (sts.kx_done) begin
               cmd.aes_start = 1'b1;
               cmd.aes_sel   = AES_ZERO;
               state_in      = S_HAES;
            end
         end
         S_HAES: begin
            if (sts.aes_done) begin
               cmd.set_hkey = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_BYTE: begin
            if (sts.fill_full) begin
               cmd.gh_start = 1'b1;
               state_in     = S_BGH;
            end else if (sts.bytes_done) begin
               cmd.count_add = 1'b1;
               state_in      = (sts.op == OP_TEXT) ? S_EMIT_TEXT : S_IDLE;
            end else if (sts.op == OP_TEXT && sts.ks_empty) begin
               cmd.aes_start = 1'b1;
               cmd.aes_sel   = AES_CTR;
               state_in      = S_CAES;
            end else begin
               cmd.byte_step = 1'b1;
            end
         end
         S_CAES: begin
            if (sts.aes_done) begin
               cmd.load_ks = 1'b1;
               state_in    = S_BYTE;
            end
         end
         S_BGH: begin
            if (sts.gh_done) begin
               state_in = S_BYTE;
            end
         end
         S_EMIT_TEXT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_TEXT;
               state_in     = S_IDLE;
            end
         end
         S_FPADW: begin
            if (sts.gh_done) begin
               state_in = S_FLEN;
            end
         end
         S_FLEN: begin
            cmd.gh_start = 1'b1;
            cmd.gh_len   = 1'b1;
            state_in     = S_FLENW;
         end
         S_FLENW: begin
            if (sts.gh_done) begin
               cmd.aes_start = 1'b1;
               cmd.aes_sel   = AES_J0;
               state_in      = S_FAESW;
            end
         end
         S_FAESW: begin
            if (sts.aes_done) begin
               cmd.tag_load = 1'b1;
               state_in     = S_EMIT_HI;
            end
         end
         S_EMIT_HI: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.decrypt) begin
                  cmd.out_sel = OUT_VERDICT;
                  state_in    = S_IDLE;
               end else begin
                  cmd.out_sel = OUT_HI;
                  state_in    = S_EMIT_LO;
               end
            end
         end
         S_EMIT_LO: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_LO;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

### rtl/aes256_gcm_stream_engine.sv
// Top level of the AES-256-GCM stream engine: register port, controller and datapath.
`default_nettype none
// Usage. Program the key, nonce and mode over the register port while the engine is idle,
// then send words on the request channel: a start word (expands the key and derives the
// hash key), any number of AAD chunks, any number of text chunks and a finish word.
// Each text chunk of 1 to 8 bytes returns one word of processed text; a finish returns
// the tag as two words in seal mode or a single verdict word in open mode.
// A start runs the key schedule and then the cipher pass that produces H. A text chunk
// waits for a cipher pass whenever a fresh keystream block is needed, and any chunk waits
// for GHASH on each completed hash block (and on the padding block before the first text).
// The one-round-per-cycle cipher and the eight-bit-per-cycle GHASH multiplier do this work.
// A finish first pads and hashes a part-filled hash block, if there is one. Only one word
// is in work at a time.
// The result sits in an output register, so the next request word is taken while a
// previous result still waits; when the receiver raises rsp_stall the engine only
// halts once it needs that register again.
// Reset is synchronous and clears hash, counter and keystream state; the round keys hold
// garbage until the first start word, so a start must come first. No clearing pass is needed.
module aes256_gcm_stream_engine #(
   parameter int unsigned ROUND_COUNT = aesgcm_pkg::ROUNDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  aesgcm_pkg::req_word_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output aesgcm_pkg::rsp_word_type rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [5:0]               paddr,
   input  logic [63:0]              pwdata,
   output logic [63:0]              prdata,
   output logic                     pready
);
   import aesgcm_pkg::*;

   logic [63:0] key_ff [4];
   logic [63:0] nonce_hi_ff;
   logic [31:0] nonce_lo_ff;
   logic        mode_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;
   cmd_type     cmd;
   sts_type     sts;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign wr_en   = psel && penable && pwrite;

   // Register file: one 64-bit register every eight bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
         nonce_hi_ff <= '0;
         nonce_lo_ff <= '0;
         mode_ff     <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_KEY0:   key_ff[0]   <= pwdata;
            REG_KEY1:   key_ff[1]   <= pwdata;
            REG_KEY2:   key_ff[2]   <= pwdata;
            REG_KEY3:   key_ff[3]   <= pwdata;
            REG_NONCEH: nonce_hi_ff <= pwdata;
            REG_NONCEL: nonce_lo_ff <= pwdata[31:0];
            REG_MODE:   mode_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY0:   prdata = key_ff[0];
         REG_KEY1:   prdata = key_ff[1];
         REG_KEY2:   prdata = key_ff[2];
         REG_KEY3:   prdata = key_ff[3];
         REG_NONCEH: prdata = nonce_hi_ff;
         REG_NONCEL: prdata = {32'h0, nonce_lo_ff};
         REG_MODE:   prdata = {63'h0, mode_ff};
         default:    prdata = '0;
      endcase
   end

   aesgcm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   aesgcm_dp #(
      .ROUND_COUNT(ROUND_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .key       ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .nonce_high(nonce_hi_ff),
      .nonce_low (nonce_lo_ff),
      .decrypt   (mode_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/aesgcm_checker.sv
// Port-level assertions for the stream engine and the bind that attaches them.
`default_nettype none

module aesgcm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input aesgcm_pkg::rsp_word_type rsp_data
);
   import aesgcm_pkg::*;

   // A result held back by the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // The engine works on one request word at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   a_text_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_TEXT |-> rsp_data.last && !rsp_data.auth_ok)
      else $error("text result not marked last");

   a_tag_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_TAG |->
         rsp_data.byte_count == 4'd8 && !rsp_data.auth_ok)
      else $error("malformed tag half");

   a_verdict_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_VERDICT |->
         rsp_data.byte_count == 4'd0 && rsp_data.data_out == 64'd0 && rsp_data.last)
      else $error("malformed verdict");

endmodule

bind aes256_gcm_stream_engine aesgcm_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire

### sim/gcm_stream_monitor.sv
// Watches the AES-256-GCM engine's channels, predicts every result word and compares it.
`timescale 1ns / 100ps

module gcm_stream_monitor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  aesgcm_pkg::req_word_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  aesgcm_pkg::rsp_word_type rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [5:0]               paddr,
   input  logic [63:0]              pwdata,
   input  logic                     pready,
   output int                       mismatches,
   output int                       words_due
);
   import aesgcm_pkg::*;

   logic [63:0]  key_reg [4];
   logic [63:0]  iv_high;
   logic [31:0]  iv_low;
   logic         opening;

   logic [127:0] rk [15];
   logic [127:0] h_key, acc, ks_blk, hbuf;
   logic [31:0]  ctr;
   logic [4:0]   ks_left, hfill;
   logic [60:0]  aad_len, txt_len;
   logic         in_text;

   rsp_word_type due_words [$];

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes_block(input logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, e;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[0][127-8*i -: 8];
      for (int r = 1; r <= 14; r++) begin
         for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) & 3)];
         if (r != 14) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               e = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ e ^ xtime(a0 ^ a1);
               t[4*c+1] = a1 ^ e ^ xtime(a1 ^ a2);
               t[4*c+2] = a2 ^ e ^ xtime(a2 ^ a3);
               t[4*c+3] = a3 ^ e ^ xtime(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r][127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
      return o;
   endfunction

   task automatic expand_key();
      logic [31:0] w [60];
      logic [31:0] t;
      for (int i = 0; i < 8; i++)
         w[i] = (i & 1) ? key_reg[i>>1][31:0] : key_reg[i>>1][63:32];
      for (int i = 8; i < 60; i++) begin
         t = w[i-1];
         if (i % 8 == 0)
            t = {SBOX[t[23:16]] ^ (8'h01 << (i/8 - 1)), SBOX[t[15:8]], SBOX[t[7:0]],
                 SBOX[t[31:24]]};
         else if (i % 8 == 4)
            t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
         w[i] = w[i-8] ^ t;
      end
      for (int r = 0; r < 15; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endtask

   // Bit-serial GF(2^128) multiply of (acc ^ blk) by the hash key, reflected convention.
   task automatic ghash(input logic [127:0] blk);
      logic [127:0] x, v, z;
      logic lsb;
      x = acc ^ blk;
      v = h_key;
      z = '0;
      for (int i = 0; i < 128; i++) begin
         if (x[127-i]) z ^= v;
         lsb = v[0];
         v = v >> 1;
         if (lsb) v[127:120] ^= 8'he1;
      end
      acc = z;
   endtask

   task automatic hash_in(input logic [7:0] b);
      hbuf[127-8*hfill[3:0] -: 8] |= b;
      hfill = {1'b0, hfill[3:0]} + 5'd1;
      if (hfill == 5'd16) begin
         ghash(hbuf);
         hbuf = '0;
         hfill = '0;
      end
   endtask

   task automatic hash_flush();
      if (hfill != 5'd0) begin
         ghash(hbuf);
         hbuf = '0;
         hfill = '0;
      end
   endtask

   task automatic gcm_apply_word(input req_word_type w);
      logic [3:0]   n;
      logic [63:0]  txt;
      logic [7:0]   ib, ob;
      logic [4:0]   pos;
      logic [127:0] tag;
      rsp_word_type r;
      n = (w.chunk_bytes > 4'd8) ? 4'd8 : w.chunk_bytes;
      case (opcode_type'(w.opcode))
         OP_START: begin
            expand_key();
            h_key = aes_block('0);
            acc = '0; ks_blk = '0; hbuf = '0;
            ks_left = '0; hfill = '0;
            aad_len = '0; txt_len = '0; in_text = 1'b0;
            ctr = 32'd1;
         end
         OP_AAD: begin
            if (!in_text && n != 4'd0) begin
               for (int k = 0; k < n; k++) hash_in(w.chunk_data[63-8*k -: 8]);
               aad_len = aad_len + {57'd0, n};
            end
         end
         OP_TEXT: begin
            if (n != 4'd0) begin
               if (!in_text) begin
                  hash_flush();
                  in_text = 1'b1;
               end
               txt = '0;
               for (int k = 0; k < n; k++) begin
                  ib = w.chunk_data[63-8*k -: 8];
                  if (ks_left == 5'd0 || ks_left > 5'd16) begin
                     ctr = ctr + 32'd1;
                     ks_blk = aes_block({iv_high, iv_low, ctr});
                     ks_left = 5'd16;
                  end
                  pos = 5'd16 - ks_left;
                  ks_left = ks_left - 5'd1;
                  ob = ib ^ ks_blk[127-8*pos[3:0] -: 8];
                  txt[63-8*k -: 8] = ob;
                  hash_in(opening ? ib : ob);
               end
               txt_len = txt_len + {57'd0, n};
               r = '{result_kind: KIND_TEXT, data_out: txt, byte_count: n,
                     auth_ok: 1'b0, last: 1'b1};
               due_words.push_back(r);
            end
         end
         default: begin
            hash_flush();
            ghash({aad_len, 3'b000, txt_len, 3'b000});
            tag = acc ^ aes_block({iv_high, iv_low, 32'd1});
            if (opening) begin
               r = '{result_kind: KIND_VERDICT, data_out: '0, byte_count: '0,
                     auth_ok: (tag == {w.expected_tag_high, w.expected_tag_low}),
                     last: 1'b1};
               due_words.push_back(r);
            end else begin
               r = '{result_kind: KIND_TAG, data_out: tag[127:64], byte_count: 4'd8,
                     auth_ok: 1'b0, last: 1'b0};
               due_words.push_back(r);
               r.data_out = tag[63:0];
               r.last = 1'b1;
               due_words.push_back(r);
            end
         end
      endcase
   endtask

   function automatic string show(input rsp_word_type v);
      return $sformatf("kind %0d data %h bytes %0d ok %b last %b",
                       v.result_kind, v.data_out, v.byte_count, v.auth_ok, v.last);
   endfunction

   task automatic report(input string what, input rsp_word_type want, input rsp_word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch (%s): want %s; got %s", $time, what, show(want), show(got));
   endtask

   // Handshakes are judged at the falling edge, where every signal is settled for the
   // rising edge that follows.
   always @(negedge clock) begin
      rsp_word_type want;
      if (reset) begin
         foreach (key_reg[i]) key_reg[i] = '0;
         iv_high = '0; iv_low = '0; opening = 1'b0;
         foreach (rk[i]) rk[i] = '0;
         h_key = '0; acc = '0; ks_blk = '0; hbuf = '0;
         ctr = '0; ks_left = '0; hfill = '0;
         aad_len = '0; txt_len = '0; in_text = 1'b0;
         due_words.delete();
         mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[paddr[4:3]] = pwdata;
               REG_NONCEH: iv_high = pwdata;
               REG_NONCEL: iv_low = pwdata[31:0];
               REG_MODE:   opening = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) gcm_apply_word(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               report("no word due", '0, rsp_data);
            end else begin
               want = due_words.pop_front();
               if (want.result_kind !== rsp_data.result_kind ||
                   want.data_out !== rsp_data.data_out ||
                   want.byte_count !== rsp_data.byte_count ||
                   want.auth_ok !== rsp_data.auth_ok ||
                   want.last !== rsp_data.last)
                  report("field", want, rsp_data);
            end
         end
      end
      words_due = due_words.size();
   end

endmodule

### sim/tb_aes256_gcm_stream_engine.sv
// Top of the AES-256-GCM engine testbench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 100ps

module tb_aes256_gcm_stream_engine;
   import aesgcm_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [5:0]   paddr = '0;
   logic [63:0]  pwdata = '0;
   logic [63:0]  prdata;
   logic         pready;

   int           mismatches, words_due;
   int           words_sent = 0;
   int           p_req = 0, p_rsp = 0;    // idle chance per cycle, in percent
   logic         hold_go = 1'b0, hold_done = 1'b0;
   int           hold_left = 0;
   int           quiet_cycles = 0;
   rsp_word_type captured [$];            // every result word taken, for replaying seals

   always #5 clock = ~clock;

   aes256_gcm_stream_engine dut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   gcm_stream_monitor watch (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .mismatches, .words_due
   );

   // The receiver stalls at random, except for one long hold-off during which the engine
   // must fill its output register and then hold back the request channel.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_go && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < p_rsp);
      end
   end

   // Result words are recorded so that a sealed message can be fed back for opening.
   // The watchdog counts cycles in which neither channel moves a word.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) captured.push_back(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [3:0] rand_bytes(input int lo, input int hi);
      return 4'($urandom_range(hi, lo));
   endfunction

   // Each call starts at a rising edge at which nothing else has been driven, and returns
   // at the edge that took the word, leaving valid high so a following word runs on.
   task automatic send_word(input opcode_type op, input logic [63:0] d, input logic [3:0] n,
                            input logic [63:0] th = '0, input logic [63:0] tl = '0);
      req_word_type w;
      logic took;
      while ($urandom_range(99) < p_req) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      w = '{opcode: op, chunk_data: d, chunk_bytes: n,
            expected_tag_high: th, expected_tag_low: tl};
      req_data <= w;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      words_sent++;
   endtask

   // Waits until every predicted word has come back, then lets the longest job
   // (a finish, or a start that returns nothing) run out before registers change.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 3'b000}; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Fresh key and nonce, now and then at the all-zero or all-one extreme.
   task automatic program_session(input logic open_mode);
      int pick;
      pick = $urandom_range(7);
      for (int i = 0; i < 4; i++)
         reg_write(REG_KEY0 + 3'(i), pick == 0 ? '0 : pick == 1 ? '1 : rand64());
      reg_write(REG_NONCEH, pick == 0 ? '0 : pick == 1 ? '1 : rand64());
      reg_write(REG_NONCEL, pick == 0 ? '0 : pick == 1 ? 64'hffff_ffff : {32'd0, $urandom});
      reg_write(REG_MODE, {63'd0, open_mode});
   endtask

   // Seals a random message, then opens the ciphertext it produced under the same key;
   // three in eight openings carry a flipped bit in the tag or, if any, the ciphertext.
   task automatic sealed_pair();
      logic [63:0] ad [$];
      logic [3:0]  adn [$];
      logic [63:0] ct [$];
      logic [3:0]  ctn [$];
      logic [63:0] pt, tag_hi, tag_lo;
      logic [3:0]  n;
      int          n_aad, n_txt, spoil, base;
      logic        hi_seen;
      n_aad = $urandom_range(4);
      n_txt = $urandom_range(10);
      hi_seen = 1'b0;
      tag_hi = '0;
      tag_lo = '0;
      program_session(1'b0);
      base = captured.size();
      send_word(OP_START, rand64(), rand_bytes(0, 15));
      for (int i = 0; i < n_aad; i++) begin
         ad.push_back(rand64());
         adn.push_back(rand_bytes(1, 8));
         send_word(OP_AAD, ad[i], adn[i]);
      end
      for (int i = 0; i < n_txt; i++) begin
         pt = rand64();
         n = rand_bytes(1, 8);
         send_word(OP_TEXT, pt, n);
      end
      send_word(OP_FINISH, rand64(), rand_bytes(0, 15), rand64(), rand64());
      drain();
      for (int i = base; i < captured.size(); i++) begin
         if (captured[i].result_kind == KIND_TEXT) begin
            ct.push_back(captured[i].data_out);
            ctn.push_back(captured[i].byte_count);
         end else if (captured[i].result_kind == KIND_TAG) begin
            if (!hi_seen) tag_hi = captured[i].data_out;
            else tag_lo = captured[i].data_out;
            hi_seen = 1'b1;
         end
      end
      spoil = $urandom_range(7);
      if (spoil == 0) tag_hi[$urandom_range(63)] ^= 1'b1;
      if (spoil == 1) tag_lo[$urandom_range(63)] ^= 1'b1;
      if (spoil == 2 && ct.size() != 0) ct[0][63 - $urandom_range(7)] ^= 1'b1;
      reg_write(REG_MODE, 64'd1);
      send_word(OP_START, '0, '0);
      foreach (ad[i]) send_word(OP_AAD, ad[i], adn[i]);
      foreach (ct[i]) send_word(OP_TEXT, ct[i], ctn[i]);
      send_word(OP_FINISH, '0, '0, tag_hi, tag_lo);
      drain();
   endtask

   // A free-form message: mostly AAD then text, but with empty and oversize chunks,
   // AAD after text, restarts and repeated finishes mixed in.
   task automatic rough_session();
      int         len, roll;
      logic       text_seen;
      logic [3:0] n;
      opcode_type op;
      text_seen = 1'b0;
      len = $urandom_range(3, 14);
      program_session(1'($urandom_range(1)));
      send_word(OP_START, rand64(), rand_bytes(0, 15));
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(99);
         if (roll < 4)
            send_word(OP_START, rand64(), rand_bytes(0, 15));
         else if (roll < 12)
            send_word(OP_FINISH, rand64(), rand_bytes(0, 15), rand64(), rand64());
         else if (roll < 22) begin
            op = (roll < 17) ? OP_AAD : OP_TEXT;
            n = roll[0] ? 4'd0 : rand_bytes(9, 15);
            send_word(op, rand64(), n);
         end
         else if (!text_seen && roll < 55)
            send_word(OP_AAD, rand64(), rand_bytes(1, 8));
         else if (roll < 60)
            send_word(OP_AAD, rand64(), rand_bytes(1, 8));
         else begin
            send_word(OP_TEXT, rand64(), rand_bytes(1, 8));
            text_seen = 1'b1;
         end
      end
      send_word(OP_FINISH, rand64(), rand_bytes(0, 15), rand64(), rand64());
      drain();
   endtask

   initial begin
      int phase_from;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      drain();

      // Directed words: all-zero key and nonce, an empty message, a repeated finish
      // and text after a finish.
      for (int i = 0; i < 4; i++) reg_write(REG_KEY0 + 3'(i), '0);
      reg_write(REG_NONCEH, '0);
      reg_write(REG_NONCEL, '0);
      reg_write(REG_MODE, '0);
      send_word(OP_START, '0, '0);
      send_word(OP_FINISH, '0, '0);
      send_word(OP_FINISH, '1, 4'hf);
      send_word(OP_TEXT, '1, 4'd8);
      drain();

      // All-one key and nonce; empty and oversize chunks and AAD that arrives too late.
      for (int i = 0; i < 4; i++) reg_write(REG_KEY0 + 3'(i), '1);
      reg_write(REG_NONCEH, '1);
      reg_write(REG_NONCEL, 64'hffff_ffff);
      send_word(OP_START, '1, 4'hf);
      send_word(OP_AAD, '1, 4'd0);
      send_word(OP_AAD, '1, 4'd8);
      send_word(OP_AAD, 64'h0123_4567_89ab_cdef, 4'hf);
      send_word(OP_TEXT, '1, 4'd0);
      send_word(OP_TEXT, '0, 4'd9);
      send_word(OP_TEXT, '1, 4'd1);
      send_word(OP_AAD, '1, 4'd5);
      send_word(OP_TEXT, 64'h8000_0000_0000_0001, 4'd3);
      send_word(OP_TEXT, '1, 4'd8);
      send_word(OP_FINISH, '0, '0, '1, '1);
      drain();

      // Opening with a tag that cannot match.
      reg_write(REG_MODE, 64'd1);
      send_word(OP_START, '0, '0);
      send_word(OP_AAD, rand64(), 4'd7);
      send_word(OP_TEXT, rand64(), 4'd8);
      send_word(OP_FINISH, '0, '0, '1, '0);
      drain();

      // Random phases: sender idles lightly and receiver heavily, then the reverse,
      // then both run flat out with one long receiver hold-off at the start.
      for (int ph = 0; ph < 3; ph++) begin
         p_req = (ph == 0) ? 13 : (ph == 1) ? 58 : 0;
         p_rsp = (ph == 0) ? 58 : (ph == 1) ? 13 : 0;
         if (ph == 2) hold_go <= 1'b1;
         phase_from = words_sent;
         while (words_sent - phase_from < 450) begin
            if ($urandom_range(9) < 7) sealed_pair();
            else rough_session();
         end
      end

      drain();
      if (mismatches == 0 && words_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
